FILE: hdl/ray_ground_point_classifier_macros.svh
// Assertion macros used by the checker file of the ray ground classifier.
// No dependencies; included by bare file name.
`ifndef RAY_GROUND_POINT_CLASSIFIER_MACROS_SVH
`define RAY_GROUND_POINT_CLASSIFIER_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define RGPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RGPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/rgpc_pkg.sv
// Package of the ray ground point classifier: widths, reset values,
// register indexes and the configuration struct. No dependencies.
`default_nettype none

package rgpc_pkg;

  localparam int TAG_WIDTH_DEF    = 16;
  localparam int RADIUS_WIDTH_DEF = 18;
  localparam int HEIGHT_W         = 18;
  localparam int SLOPE_W          = 24;
  localparam int CONC_W           = 18;
  localparam int MINH_W           = 17;
  localparam int RECL_W           = 18;
  localparam int FRAC_W           = 16;
  localparam int CFG_AW           = 5;
  localparam int CFG_DW           = 32;

  localparam logic [SLOPE_W-1:0] LOCAL_SLOPE_RST   = 24'd5734;
  localparam logic [SLOPE_W-1:0] GENERAL_SLOPE_RST = 24'd3434;
  localparam logic [CONC_W-1:0]  CONC_STEP_RST     = 18'd0;
  localparam logic [MINH_W-1:0]  MIN_HEIGHT_RST    = 17'd50;
  localparam logic [RECL_W-1:0]  RECLASS_RST       = 18'd200;

  typedef enum logic [2:0] {
    REG_LOCAL_SLOPE   = 3'd0,
    REG_GENERAL_SLOPE = 3'd1,
    REG_CONC_STEP     = 3'd2,
    REG_MIN_HEIGHT    = 3'd3,
    REG_RECLASS       = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [SLOPE_W-1:0] local_slope;
    logic [SLOPE_W-1:0] general_slope;
    logic [CONC_W-1:0]  conc_step;
    logic [MINH_W-1:0]  min_height;
    logic [RECL_W-1:0]  reclass;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hdl/rgpc_regs.sv
// APB configuration registers of the ray ground point classifier.
// Depends on rgpc_pkg.
`default_nettype none

module rgpc_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rgpc_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [rgpc_pkg::CFG_DW-1:0]  pwdata,
  output logic      [rgpc_pkg::CFG_DW-1:0]  prdata,
  output logic                              pready,
  output rgpc_pkg::cfg_t                    cfg_o
);
  import rgpc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_LOCAL_SLOPE:   cfg_d.local_slope   = pwdata[SLOPE_W-1:0];
        REG_GENERAL_SLOPE: cfg_d.general_slope = pwdata[SLOPE_W-1:0];
        REG_CONC_STEP:     cfg_d.conc_step     = pwdata[CONC_W-1:0];
        REG_MIN_HEIGHT:    cfg_d.min_height    = pwdata[MINH_W-1:0];
        REG_RECLASS:       cfg_d.reclass       = pwdata[RECL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LOCAL_SLOPE:   prdata = CFG_DW'(cfg_q.local_slope);
      REG_GENERAL_SLOPE: prdata = CFG_DW'(cfg_q.general_slope);
      REG_CONC_STEP:     prdata = CFG_DW'(cfg_q.conc_step);
      REG_MIN_HEIGHT:    prdata = CFG_DW'(cfg_q.min_height);
      REG_RECLASS:       prdata = CFG_DW'(cfg_q.reclass);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_slope   <= LOCAL_SLOPE_RST;
      cfg_q.general_slope <= GENERAL_SLOPE_RST;
      cfg_q.conc_step     <= CONC_STEP_RST;
      cfg_q.min_height    <= MIN_HEIGHT_RST;
      cfg_q.reclass       <= RECLASS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rgpc_eval.sv
// Ground decision for one registered point: threshold floor, local test,
// slope-from-origin fallback and reclassification. Depends on rgpc_pkg.
`default_nettype none

module rgpc_eval #(
  parameter int RADIUS_WIDTH = rgpc_pkg::RADIUS_WIDTH_DEF,
  localparam int STEP_W = RADIUS_WIDTH + 1,
  localparam int THR_W  = rgpc_pkg::SLOPE_W + 1 + STEP_W - rgpc_pkg::FRAC_W,
  localparam int GTHR_W = rgpc_pkg::SLOPE_W + RADIUS_WIDTH - rgpc_pkg::FRAC_W
) (
  input  wire logic signed [THR_W-1:0]              thr_i,
  input  wire logic        [GTHR_W-1:0]             gthr_i,
  input  wire logic signed [STEP_W-1:0]             step_i,
  input  wire logic signed [rgpc_pkg::HEIGHT_W-1:0] height_i,
  input  wire logic signed [rgpc_pkg::HEIGHT_W-1:0] last_height_i,
  input  wire logic                                 last_ground_i,
  input  wire rgpc_pkg::cfg_t                       cfg_i,
  output logic                                      ground_o
);
  import rgpc_pkg::*;

  localparam int CW = THR_W + 2;

  logic signed [CW-1:0] thr_x, thr_f, gthr_x, step_x, h_x, lh_x;
  logic signed [CW-1:0] conc_x, minh_x, recl_x;
  logic                 local_ok, gen_ok, recl_ok;

  always_comb begin
    thr_x  = CW'(thr_i);
    step_x = CW'(step_i);
    h_x    = CW'(height_i);
    lh_x   = CW'(last_height_i);
    gthr_x = signed'(CW'(gthr_i));
    conc_x = signed'(CW'(cfg_i.conc_step));
    minh_x = signed'(CW'(cfg_i.min_height));
    recl_x = signed'(CW'(cfg_i.reclass));

    thr_f = (step_x > conc_x && thr_x < minh_x) ? minh_x : thr_x;

    local_ok = (h_x <= lh_x + thr_f) && (h_x >= lh_x - thr_f);
    gen_ok   = (h_x <= gthr_x) && (h_x >= -gthr_x);
    recl_ok  = (step_x > recl_x) && (h_x <= thr_f) && (h_x >= -thr_f);

    if (local_ok) begin
      ground_o = last_ground_i | gen_ok;
    end else begin
      ground_o = recl_ok;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ray_ground_point_classifier.sv
// Top level of the ray ground point classifier: stream ports, APB registers,
// product stage and result register. Depends on rgpc_pkg, rgpc_regs, rgpc_eval.
//
//  channel  | dir | accepted when                  | payload
//  ---------+-----+--------------------------------+------------------------------
//  s_axis   | in  | s_axis_tvalid & s_axis_tready  | radius, height, tag; tuser=ray_start
//  m_axis   | out | m_axis_tvalid & m_axis_tready  | tag_out; tuser=is_ground
//  apb      | in  | psel & penable & pwrite        | register write, pready always 1
//
// One item per cycle sustained while the output is not stalled; a result passes the
// stage-one registers and then the result register before it is valid on m_axis.
// Stage one forms the step and both slope products (one multiplier each);
// stage two compares against the last result's ground flag and fills the output.
// Reset clears the previous-point state and loads the register defaults.
// A stalled output holds; input is still taken while the product stage is free.
`default_nettype none

module ray_ground_point_classifier #(
  parameter int TAG_WIDTH    = rgpc_pkg::TAG_WIDTH_DEF,
  parameter int RADIUS_WIDTH = rgpc_pkg::RADIUS_WIDTH_DEF,
  localparam int S_DW = ((RADIUS_WIDTH + rgpc_pkg::HEIGHT_W + TAG_WIDTH + 7) / 8) * 8,
  localparam int M_DW = ((TAG_WIDTH + 7) / 8) * 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata from bit 0 up: radius, height, point_tag, zero fill
  input  wire logic [S_DW-1:0]              s_axis_tdata,
  // tuser: ray_start
  input  wire logic                         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // tdata from bit 0 up: tag_out, zero fill
  output logic      [M_DW-1:0]              m_axis_tdata,
  // tuser: is_ground
  output logic                              m_axis_tuser,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rgpc_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [rgpc_pkg::CFG_DW-1:0]  pwdata,
  output logic      [rgpc_pkg::CFG_DW-1:0]  prdata,
  output logic                              pready
);
  import rgpc_pkg::*;

  localparam int STEP_W  = RADIUS_WIDTH + 1;
  localparam int LPROD_W = SLOPE_W + 1 + STEP_W;
  localparam int THR_W   = LPROD_W - FRAC_W;
  localparam int GPROD_W = SLOPE_W + RADIUS_WIDTH;
  localparam int GTHR_W  = GPROD_W - FRAC_W;
  localparam int H_LO    = RADIUS_WIDTH;
  localparam int T_LO    = RADIUS_WIDTH + HEIGHT_W;

  cfg_t cfg;

  logic [RADIUS_WIDTH-1:0]    in_r;
  logic signed [HEIGHT_W-1:0] in_h;
  logic [TAG_WIDTH-1:0]       in_tag;
  logic                       s_acc, adv;

  logic [RADIUS_WIDTH-1:0]    prev_r_q;
  logic signed [HEIGHT_W-1:0] prev_h_q;
  logic [RADIUS_WIDTH-1:0]    base_r;
  logic signed [HEIGHT_W-1:0] base_h;

  logic signed [STEP_W-1:0]   step_d;
  logic signed [SLOPE_W:0]    lslope_s;
  logic signed [LPROD_W-1:0]  lprod;
  logic [GPROD_W-1:0]         gprod;

  logic                       v1_q, start1_q;
  logic signed [THR_W-1:0]    thr1_q;
  logic [GTHR_W-1:0]          gthr1_q;
  logic signed [STEP_W-1:0]   step1_q;
  logic signed [HEIGHT_W-1:0] h1_q, lh1_q;
  logic [TAG_WIDTH-1:0]       tag1_q;

  logic                       vo_q, ground_q, lwg_q;
  logic [TAG_WIDTH-1:0]       tag_q;
  logic                       ground_d;

  rgpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_r   = s_axis_tdata[RADIUS_WIDTH-1:0];
  assign in_h   = signed'(s_axis_tdata[T_LO-1:H_LO]);
  assign in_tag = s_axis_tdata[T_LO+TAG_WIDTH-1:T_LO];

  assign adv           = !vo_q || m_axis_tready;
  assign s_axis_tready = !v1_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // ray start restarts from the origin
  assign base_r = s_axis_tuser ? '0 : prev_r_q;
  assign base_h = s_axis_tuser ? '0 : prev_h_q;

  always_comb begin
    step_d   = signed'(STEP_W'(in_r)) - signed'(STEP_W'(base_r));
    lslope_s = signed'({1'b0, cfg.local_slope});
    lprod    = LPROD_W'(lslope_s) * LPROD_W'(step_d);
    gprod    = GPROD_W'(cfg.general_slope) * GPROD_W'(in_r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_r_q <= '0;
      prev_h_q <= '0;
      v1_q     <= 1'b0;
      start1_q <= 1'b0;
    end else begin
      if (s_acc) begin
        prev_r_q <= in_r;
        prev_h_q <= in_h;
        v1_q     <= 1'b1;
        start1_q <= s_axis_tuser;
      end else if (adv) begin
        v1_q <= 1'b0;
      end
    end
  end

  // upper product bits give the floor of the Q16 scaling
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      thr1_q  <= lprod[LPROD_W-1:FRAC_W];
      gthr1_q <= gprod[GPROD_W-1:FRAC_W];
      step1_q <= step_d;
      h1_q    <= in_h;
      lh1_q   <= base_h;
      tag1_q  <= in_tag;
    end
  end

  rgpc_eval #(
    .RADIUS_WIDTH (RADIUS_WIDTH)
  ) u_eval (
    .thr_i         (thr1_q),
    .gthr_i        (gthr1_q),
    .step_i        (step1_q),
    .height_i      (h1_q),
    .last_height_i (lh1_q),
    .last_ground_i (lwg_q && !start1_q),
    .cfg_i         (cfg),
    .ground_o      (ground_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q  <= 1'b0;
      lwg_q <= 1'b0;
    end else if (adv) begin
      vo_q <= v1_q;
      if (v1_q) begin
        lwg_q <= ground_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v1_q) begin
      tag_q    <= tag1_q;
      ground_q <= ground_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = M_DW'(tag_q);
  assign m_axis_tuser  = ground_q;

endmodule

`default_nettype wire

FILE: hdl/rgpc_checker.sv
// Port-level checker of the ray ground point classifier, bound to the top.
// Depends on ray_ground_point_classifier_macros.svh and rgpc_pkg.
`default_nettype none

`include "ray_ground_point_classifier_macros.svh"

module rgpc_checker #(
  parameter int TAG_WIDTH = rgpc_pkg::TAG_WIDTH_DEF,
  localparam int M_DW = ((TAG_WIDTH + 7) / 8) * 8
) (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            s_axis_tvalid,
  input wire logic            s_axis_tready,
  input wire logic            m_axis_tvalid,
  input wire logic            m_axis_tready,
  input wire logic [M_DW-1:0] m_axis_tdata,
  input wire logic            m_axis_tuser
);

  logic          out_stall;
  logic          in_acc;
  logic [M_DW:0] out_word;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_word  = {m_axis_tuser, m_axis_tdata};

  // input register then result register lie between an input item and its result
  `RGPC_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid, "stalled item dropped")
  `RGPC_ASSERT(a_out_stable, clk_i, rst_ni, out_stall |=> $stable(out_word), "item changed")
  `RGPC_ASSERT(a_out_src, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(in_acc, 2), "orphan item")
  `RGPC_ASSERT_ALWAYS(a_no_bubble, clk_i, m_axis_tready |-> s_axis_tready, "ready not passed back")

endmodule

bind ray_ground_point_classifier rgpc_checker #(
  .TAG_WIDTH (TAG_WIDTH)
) u_rgpc_checker (.*);

`default_nettype wire
